// ===== rtl/core/led_strip_pattern_buffer_macros.svh =====
// assertion macros shared by the led strip pattern buffer rtl
`ifndef LED_STRIP_PATTERN_BUFFER_MACROS_SVH
`define LED_STRIP_PATTERN_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LSPB_ASSERT_IMP(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LSPB_ASSERT_NXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== rtl/core/lspb_pkg.sv =====
// shared types and constants of the led strip pattern buffer
package lspb_pkg;

    localparam int COLOUR_W    = 32;
    localparam int NUM_COLOURS = 6;
    localparam int COUNT_W     = 9;

    typedef enum logic [2:0] {
        CMD_RAINBOW = 3'd0,
        CMD_ROTATE  = 3'd1,
        CMD_SHIFT   = 3'd2,
        CMD_SOLID   = 3'd3,
        CMD_SET_ONE = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_STRIP_LEN      = 3'd0,
        CFG_COLOUR_RED     = 3'd1,
        CFG_COLOUR_YELLOW  = 3'd2,
        CFG_COLOUR_GREEN   = 3'd3,
        CFG_COLOUR_CYAN    = 3'd4,
        CFG_COLOUR_BLUE    = 3'd5,
        CFG_COLOUR_MAGENTA = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_STEP,
        ST_SWEEP
    } state_t;

    // one step of the cell row per cycle, at most one of these set
    typedef struct packed {
        logic fwd_step;
        logic bwd_step;
    } cell_ctrl_t;

    localparam logic [COUNT_W-1:0] STRIP_LEN_RESET = 9'd256;

    localparam logic [COLOUR_W-1:0] PALETTE_RESET [NUM_COLOURS] = '{
        32'h00FF_0000,
        32'h00FF_FF00,
        32'h0000_FF00,
        32'h0000_FFFF,
        32'h0000_00FF,
        32'h00FF_00FF
    };

endpackage

// ===== rtl/core/lspb_cell.sv =====
// one storage cell of the led row: holds one colour word
module lspb_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lspb_pkg::cell_ctrl_t           ctrl,
    input  logic [CW-1:0]                  n,
    input  logic [lspb_pkg::COLOUR_W-1:0]  left_val,
    input  logic [lspb_pkg::COLOUR_W-1:0]  right_val,
    input  logic [lspb_pkg::COLOUR_W-1:0]  ins,
    output logic [lspb_pkg::COLOUR_W-1:0]  val
);

    localparam logic [CW-1:0] POS    = CW'(INDEX);
    localparam logic [CW-1:0] POS_P1 = CW'(INDEX + 1);

    logic                          active;
    logic                          last;
    logic [lspb_pkg::COLOUR_W-1:0] val_reg;
    logic [lspb_pkg::COLOUR_W-1:0] val_next;

    assign active = (POS < n);
    assign last   = (n == POS_P1);

    always_comb
    begin
        val_next = val_reg;
        if (active && ctrl.fwd_step)
        begin
            val_next = left_val;
        end
        else if (active && ctrl.bwd_step)
        begin
            // last used cell takes the wrap value
            val_next = last ? ins : right_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

// ===== rtl/core/lspb_chain.sv =====
// row of led cells with insertion at either end
module lspb_chain #(
    parameter int MAX_LEDS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lspb_pkg::cell_ctrl_t                ctrl,
    input  logic [$clog2(MAX_LEDS + 1)-1:0]     n,
    input  logic [lspb_pkg::COLOUR_W-1:0]       ins,
    output logic [lspb_pkg::COLOUR_W-1:0]       head
);

    localparam int CW = $clog2(MAX_LEDS + 1);

    logic [lspb_pkg::COLOUR_W-1:0] val [MAX_LEDS];

    for (genvar i = 0; i < MAX_LEDS; i++)
    begin : g_cell
        logic [lspb_pkg::COLOUR_W-1:0] left_val;
        logic [lspb_pkg::COLOUR_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = ins;
        end
        else
        begin : g_mid_l
            assign left_val = val[i-1];
        end

        if (i == MAX_LEDS - 1)
        begin : g_end
            assign right_val = ins;
        end
        else
        begin : g_mid_r
            assign right_val = val[i+1];
        end

        lspb_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .n         (n),
            .left_val  (left_val),
            .right_val (right_val),
            .ins       (ins),
            .val       (val[i])
        );
    end

    assign head = val[0];

endmodule

// ===== rtl/core/led_strip_pattern_buffer.sv =====
// top level of the led strip pattern buffer: command control and config registers
//
// usage
//   command channel: a command beat is taken on a rising edge with start high and
//   busy low; command, forward, step_count, colour and index are sampled with it.
//   result channel: done is high for exactly one cycle per command, with
//   read_colour and bad_index valid in that cycle; the receiver cannot stall it.
//   config port: cfg_write with cfg_index/cfg_data writes the strip length (0) or
//   one of the six rainbow colours (1..6) at once; write only while busy is low.
// work per command, with n = min(strip length, MAX_LEDS), s = step_count
//   rainbow, solid, set one, read: one pass around the cell row
//   rotate backward, shift fill: s single-position steps
//   rotate forward: repeated subtraction of n from s for the remainder, then
//   (n - s mod n) mod n backward steps, then the result
//   flagged index, n of zero, zero steps, unused codes: answered without moving the row
//   one command at a time; busy stays high until it is through, with the row of cells
//   moving one position per cycle while it works
// reset: all cell words go to zero, strip length to 256, palette to its defaults
`include "led_strip_pattern_buffer_macros.svh"

module led_strip_pattern_buffer #(
    parameter int MAX_LEDS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            command,
    input  logic                                  forward,
    input  logic [7:0]                            step_count,
    input  logic [lspb_pkg::COLOUR_W-1:0]         colour,
    input  logic [7:0]                            index,
    // result channel
    output logic                                  done,
    output logic [lspb_pkg::COLOUR_W-1:0]         read_colour,
    output logic                                  bad_index,
    // config port
    input  logic                                  cfg_write,
    input  logic [2:0]                            cfg_index,
    input  logic [lspb_pkg::COLOUR_W-1:0]         cfg_data
);

    localparam int CW  = $clog2(MAX_LEDS + 1);
    localparam int WW  = (CW > lspb_pkg::COUNT_W) ? CW : lspb_pkg::COUNT_W;
    localparam int SKW = WW + 3;
    localparam int CSW = $clog2(lspb_pkg::NUM_COLOURS);

    // config registers
    logic [lspb_pkg::COUNT_W-1:0]  strip_len_reg;
    logic [lspb_pkg::COLOUR_W-1:0] palette_reg [lspb_pkg::NUM_COLOURS];

    // control state
    lspb_pkg::state_t              state_reg, state_next;
    logic [7:0]                    rem_reg, rem_next;
    logic [WW-1:0]                 cnt_reg, cnt_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [SKW-1:0]                six_k_reg, six_k_next;
    logic [lspb_pkg::COLOUR_W-1:0] rd_reg, rd_next;
    logic                          bad_reg, bad_next;
    logic                          done_reg, done_next;

    // latched command beat
    lspb_pkg::cmd_t                cmd_reg;
    logic                          fwd_reg;
    logic [lspb_pkg::COLOUR_W-1:0] colour_reg;
    logic [7:0]                    idx_reg;

    // decode and datapath
    lspb_pkg::cmd_t                cmd_in;
    logic                          accept;
    logic [WW-1:0]                 n_wide;
    logic                          n_nonzero;
    logic                          step_nz;
    logic                          idx_ok;
    logic                          go_sweep, go_mod, go_step, in_bad;
    logic                          rem_ge_n;
    logic                          k_hit, k_last;
    logic [CSW-1:0]                col_sel;
    lspb_pkg::cell_ctrl_t          cell_ctrl;
    logic [lspb_pkg::COLOUR_W-1:0] ins_val;
    logic [lspb_pkg::COLOUR_W-1:0] head_val;

    assign cmd_in    = lspb_pkg::cmd_t'(command);
    assign accept    = start && (state_reg == lspb_pkg::ST_IDLE);

    // effective count: strip length clamped to the row length
    assign n_wide    = (WW'(strip_len_reg) > WW'(MAX_LEDS)) ? WW'(MAX_LEDS)
                                                            : WW'(strip_len_reg);
    assign n_nonzero = (n_wide != '0);
    assign step_nz   = (step_count != 8'd0);
    assign idx_ok    = (WW'(index) < n_wide);

    assign rem_ge_n  = (WW'(rem_reg) >= n_wide);
    assign k_hit     = (WW'(k_reg) == WW'(idx_reg));
    assign k_last    = (WW'(k_reg) == (n_wide - WW'(1)));

    // work needed by the incoming command
    always_comb
    begin
        go_sweep = 1'b0;
        go_mod   = 1'b0;
        go_step  = 1'b0;
        in_bad   = 1'b0;
        case (cmd_in) inside
            lspb_pkg::CMD_RAINBOW, lspb_pkg::CMD_SOLID:
            begin
                go_sweep = n_nonzero;
            end
            lspb_pkg::CMD_ROTATE:
            begin
                // forward rotate goes the other way round by n - s mod n
                go_mod  = n_nonzero && step_nz && forward;
                go_step = n_nonzero && step_nz && !forward;
            end
            lspb_pkg::CMD_SHIFT:
            begin
                go_step = n_nonzero && step_nz;
            end
            lspb_pkg::CMD_SET_ONE, lspb_pkg::CMD_READ:
            begin
                go_sweep = idx_ok;
                in_bad   = !idx_ok;
            end
            default:
            begin
            end
        endcase
    end

    // rainbow colour number: count of thresholds t*n passed by 6*k
    always_comb
    begin
        col_sel = '0;
        for (int t = 1; t < lspb_pkg::NUM_COLOURS; t++)
        begin
            if (six_k_reg >= (SKW'(n_wide) * SKW'(t)))
            begin
                col_sel = CSW'(t);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lspb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (go_sweep)
                    begin
                        state_next = lspb_pkg::ST_SWEEP;
                    end
                    else if (go_mod)
                    begin
                        state_next = lspb_pkg::ST_MOD;
                    end
                    else if (go_step)
                    begin
                        state_next = lspb_pkg::ST_STEP;
                    end
                end
            end
            lspb_pkg::ST_MOD:
            begin
                if (!rem_ge_n)
                begin
                    state_next = (rem_reg == 8'd0) ? lspb_pkg::ST_IDLE : lspb_pkg::ST_STEP;
                end
            end
            lspb_pkg::ST_STEP:
            begin
                if (cnt_reg == WW'(1))
                begin
                    state_next = lspb_pkg::ST_IDLE;
                end
            end
            lspb_pkg::ST_SWEEP:
            begin
                if (k_last)
                begin
                    state_next = lspb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lspb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        six_k_next = six_k_reg;
        rd_next    = rd_reg;
        bad_next   = bad_reg;
        done_next  = 1'b0;
        cell_ctrl  = '0;
        ins_val    = head_val;
        unique case (state_reg)
            lspb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next   = step_count;
                    cnt_next   = WW'(step_count);
                    k_next     = '0;
                    six_k_next = '0;
                    rd_next    = '0;
                    bad_next   = in_bad;
                    // nothing to move: answer in the next cycle
                    done_next  = !(go_sweep || go_mod || go_step);
                end
            end
            lspb_pkg::ST_MOD:
            begin
                if (rem_ge_n)
                begin
                    rem_next = rem_reg - n_wide[7:0];
                end
                else
                begin
                    cnt_next  = n_wide - WW'(rem_reg);
                    done_next = (rem_reg == 8'd0);
                end
            end
            lspb_pkg::ST_STEP:
            begin
                cnt_next  = cnt_reg - WW'(1);
                done_next = (cnt_reg == WW'(1));
                if (cmd_reg == lspb_pkg::CMD_SHIFT)
                begin
                    ins_val            = colour_reg;
                    cell_ctrl.fwd_step = fwd_reg;
                    cell_ctrl.bwd_step = !fwd_reg;
                end
                else
                begin
                    // rotate: head wraps round to the last used cell
                    cell_ctrl.bwd_step = 1'b1;
                end
            end
            lspb_pkg::ST_SWEEP:
            begin
                // entry k sits at the head; what wraps in now ends up at entry k
                k_next             = k_reg + CW'(1);
                six_k_next         = six_k_reg + SKW'(lspb_pkg::NUM_COLOURS);
                done_next          = k_last;
                cell_ctrl.bwd_step = 1'b1;
                case (cmd_reg)
                    lspb_pkg::CMD_RAINBOW:
                    begin
                        ins_val = palette_reg[col_sel];
                    end
                    lspb_pkg::CMD_SOLID:
                    begin
                        ins_val = colour_reg;
                    end
                    lspb_pkg::CMD_SET_ONE:
                    begin
                        if (k_hit)
                        begin
                            ins_val = colour_reg;
                        end
                    end
                    lspb_pkg::CMD_READ:
                    begin
                        if (k_hit)
                        begin
                            rd_next = head_val;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lspb_pkg::ST_IDLE;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            k_reg     <= '0;
            six_k_reg <= '0;
            rd_reg    <= '0;
            bad_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            six_k_reg <= six_k_next;
            rd_reg    <= rd_next;
            bad_reg   <= bad_next;
            done_reg  <= done_next;
        end
    end

    // command beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_in;
            fwd_reg    <= forward;
            colour_reg <= colour;
            idx_reg    <= index;
        end
    end

    // config registers; index 7 is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_len_reg <= lspb_pkg::STRIP_LEN_RESET;
            for (int c = 0; c < lspb_pkg::NUM_COLOURS; c++)
            begin
                palette_reg[c] <= lspb_pkg::PALETTE_RESET[c];
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                lspb_pkg::CFG_STRIP_LEN:
                begin
                    strip_len_reg <= cfg_data[lspb_pkg::COUNT_W-1:0];
                end
                [lspb_pkg::CFG_COLOUR_RED:lspb_pkg::CFG_COLOUR_MAGENTA]:
                begin
                    palette_reg[cfg_index - 3'd1] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // the led store itself
    lspb_chain #(
        .MAX_LEDS (MAX_LEDS)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cell_ctrl),
        .n     (n_wide[CW-1:0]),
        .ins   (ins_val),
        .head  (head_val)
    );

    assign busy        = (state_reg != lspb_pkg::ST_IDLE);
    assign done        = done_reg;
    assign read_colour = rd_reg;
    assign bad_index   = bad_reg;

    // checks
    `LSPB_ASSERT_NXT(a_accept_answered, accept, busy || done, "command beat neither running nor answered")
    `LSPB_ASSERT_IMP(a_done_source, done, $past(accept) || $past(state_reg != lspb_pkg::ST_IDLE), "result beat without a command")
    `LSPB_ASSERT_IMP(a_bad_reads_zero, done && bad_index, read_colour == '0, "flagged index returned a colour")
    `LSPB_ASSERT_IMP(a_sweep_in_range, state_reg == lspb_pkg::ST_SWEEP, WW'(k_reg) < n_wide, "sweep position past led count")
    `LSPB_ASSERT_IMP(a_step_count, state_reg == lspb_pkg::ST_STEP, cnt_reg != '0, "step phase with no steps left")

endmodule
